### rtl/core/madt_lae_pkg.sv
// Package for the MADT local APIC enumerator: item and result types,
// result and operation codes, entry layout constants.
// No dependencies.
package madt_lae_pkg;

  localparam int MAX_CPUS_DEF = 16;
  localparam int ID_W         = 8;
  localparam int IDX_W        = 4;
  localparam int CNT_OUT_W    = 5;
  localparam int PADDR_W      = 3;

  // operation codes
  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // configuration register indexes (word address)
  localparam logic [0:0] REG_BSP_APIC_ID = 1'b0;

  // entry layout
  localparam logic [7:0] OFS_TYPE        = 8'd0;
  localparam logic [7:0] OFS_LENGTH      = 8'd1;
  localparam logic [7:0] OFS_APIC_ID     = 8'd3;
  localparam logic [7:0] OFS_FLAGS       = 8'd4;
  localparam logic [7:0] OFS_LAST        = 8'd7;
  localparam logic [7:0] TYPE_LOCAL_APIC = 8'd0;
  localparam logic [7:0] LAPIC_ENTRY_LEN = 8'd8;
  localparam logic [7:0] MIN_ENTRY_LEN   = 8'd2;

  typedef enum logic [1:0] {
    KIND_CPU    = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_LOOKUP = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic              operation;
    logic [7:0]        data_byte;
    logic              first_byte;
    logic              last_byte;
    logic [ID_W-1:0]   query_apic_id;
  } item_t;

  typedef struct packed {
    result_kind_t         result_kind;
    logic [IDX_W-1:0]     proc_index;
    logic [ID_W-1:0]      apic_id;
    logic                 found;
    logic [CNT_OUT_W-1:0] cpu_count;
    logic                 malformed;
    logic                 last_result;
  } result_t;

  // request bundle from the parser to the id map
  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic [ID_W-1:0]   wr_id;
    logic [IDX_W-1:0]  wr_index;
    logic              rd_en;
    logic [ID_W-1:0]   rd_id;
  } map_req_t;

endpackage

### rtl/core/madt_lae_map.sv
// Id map of the MADT local APIC enumerator: per-id valid flags in flip-flops
// and the id-to-index memory with a registered read.
// Depends on madt_lae_pkg.
module madt_lae_map (
  input  logic                           clk,
  input  logic                           rst,
  input  madt_lae_pkg::map_req_t         req,
  input  logic [madt_lae_pkg::ID_W-1:0]  chk_id,
  output logic                           chk_valid,
  output logic                           rd_hit,
  output logic [madt_lae_pkg::IDX_W-1:0] rd_index
);

  localparam int Depth = 2 ** madt_lae_pkg::ID_W;

  logic [Depth-1:0]                 id_valid;
  logic [madt_lae_pkg::IDX_W-1:0]   id_to_index [Depth];

  assign chk_valid = id_valid[chk_id];

  // clear on a first byte; a write in the same cycle sets its flag again
  always_ff @(posedge clk) begin
    if (rst) begin
      id_valid <= '0;
    end else begin
      if (req.clear) begin
        id_valid <= '0;
      end
      if (req.wr_en) begin
        id_valid[req.wr_id] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_hit <= id_valid[req.rd_id];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      id_to_index[req.wr_id] <= req.wr_index;
    end
    if (req.rd_en) begin
      rd_index <= id_to_index[req.rd_id];
    end
  end

endmodule

### rtl/core/madt_local_apic_enumerator_top.sv
// MADT local APIC enumerator, top level: entry parser, result stage, output
// register and configuration port. Depends on madt_lae_pkg and madt_lae_map.
//
// Feed the MADT entry area one byte per transfer (operation = table byte),
// marking the first and the final byte. The first byte clears the map and
// registers the boot processor (bsp_apic_id, written over the APB port) as
// index 0. Each enabled local APIC entry of at least 8 bytes registers its
// APIC id when its 8th byte arrives; duplicates and entries beyond MAX_CPUS
// processors are dropped. The final byte yields a done result carrying the
// processor count and the malformed flag. A lookup transfer returns the
// dense index of an APIC id, or 0 with found low. An item that produces two
// results (a registration followed by the done result) holds the result
// stage until both have moved out; the output register is the limit, since it
// holds one result at a time. A result passes through the result stage and
// then the output register; lookups read the id-to-index memory on the
// transfer edge itself, in step with the result stage, so the registered
// read adds no latency. There is no clearing pass: valid flags are flip-flops
// cleared at reset and on every first byte.
module madt_local_apic_enumerator_top #(
  parameter int MAX_CPUS = madt_lae_pkg::MAX_CPUS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // item channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  madt_lae_pkg::item_t              in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output madt_lae_pkg::result_t            out_data,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [madt_lae_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int CntW = $clog2(MAX_CPUS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_CPUS);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [madt_lae_pkg::ID_W-1:0] bsp_apic_id;
  logic                          cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[madt_lae_pkg::PADDR_W-1:2] == madt_lae_pkg::REG_BSP_APIC_ID);
  assign prdata  = cfg_hit ? {24'd0, bsp_apic_id} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bsp_apic_id <= '0;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      bsp_apic_id <= pwdata[madt_lae_pkg::ID_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------
  logic [CntW-1:0] registered_count, registered_count_next;
  logic [7:0]      entry_offset, entry_offset_next;
  logic [7:0]      entry_type, entry_type_next;
  logic [7:0]      entry_length, entry_length_next;
  logic [7:0]      entry_apic_id, entry_apic_id_next;
  logic            entry_enabled, entry_enabled_next;
  logic            parse_stopped, parse_stopped_next;

  logic            accept;
  logic            accept_byte;
  logic            reg_bsp;
  logic            reg_entry;
  logic [CntW-1:0] count_base;
  logic [8:0]      offset_inc;
  logic            chk_valid;
  logic            has_results;

  madt_lae_pkg::map_req_t map_req;
  logic                   rd_hit;
  logic [madt_lae_pkg::IDX_W-1:0] rd_index;

  assign accept      = in_valid && in_ready;
  assign accept_byte = accept && (in_data.operation == madt_lae_pkg::OP_BYTE);

  // Work out the state after one table byte. A first byte starts from a
  // cleared entry and a count of one (the boot processor always fits).
  always_comb begin
    reg_bsp            = accept_byte && in_data.first_byte;
    reg_entry          = 1'b0;
    count_base         = registered_count;
    entry_offset_next  = entry_offset;
    entry_type_next    = entry_type;
    entry_length_next  = entry_length;
    entry_apic_id_next = entry_apic_id;
    entry_enabled_next = entry_enabled;
    parse_stopped_next = parse_stopped;
    offset_inc         = '0;

    if (in_data.first_byte) begin
      count_base         = '0;
      entry_offset_next  = '0;
      entry_type_next    = '0;
      entry_length_next  = '0;
      entry_apic_id_next = '0;
      entry_enabled_next = 1'b0;
      parse_stopped_next = 1'b0;
    end
    registered_count_next = reg_bsp ? CntW'(1) : count_base;

    if (!parse_stopped_next) begin
      case (entry_offset_next)
        madt_lae_pkg::OFS_TYPE:    entry_type_next = in_data.data_byte;
        madt_lae_pkg::OFS_LENGTH: begin
          entry_length_next = in_data.data_byte;
          if (in_data.data_byte < madt_lae_pkg::MIN_ENTRY_LEN) begin
            parse_stopped_next = 1'b1;
          end
        end
        madt_lae_pkg::OFS_APIC_ID: entry_apic_id_next = in_data.data_byte;
        madt_lae_pkg::OFS_FLAGS:   entry_enabled_next = in_data.data_byte[0];
        madt_lae_pkg::OFS_LAST: begin
          // never reached on a first byte, so the old count applies
          reg_entry = accept_byte &&
                      (entry_type == madt_lae_pkg::TYPE_LOCAL_APIC) &&
                      (entry_length >= madt_lae_pkg::LAPIC_ENTRY_LEN) &&
                      entry_enabled && (registered_count < MaxCnt) && !chk_valid;
          if (reg_entry) begin
            registered_count_next = registered_count + CntW'(1);
          end
        end
        default: ;
      endcase

      if (parse_stopped_next) begin
        entry_offset_next = '0;
      end else begin
        offset_inc = {1'b0, entry_offset_next} + 9'd1;
        if (offset_inc >= 9'd2 && offset_inc >= {1'b0, entry_length_next}) begin
          entry_offset_next  = '0;
          entry_type_next    = '0;
          entry_length_next  = '0;
          entry_apic_id_next = '0;
          entry_enabled_next = 1'b0;
        end else begin
          entry_offset_next = offset_inc[7:0];
        end
      end
    end

    if (in_data.last_byte) begin
      entry_offset_next  = '0;
      entry_type_next    = '0;
      entry_length_next  = '0;
      entry_apic_id_next = '0;
      entry_enabled_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      registered_count <= '0;
      entry_offset     <= '0;
      entry_type       <= '0;
      entry_length     <= '0;
      entry_apic_id    <= '0;
      entry_enabled    <= 1'b0;
      parse_stopped    <= 1'b0;
    end else if (accept_byte) begin
      registered_count <= registered_count_next;
      entry_offset     <= entry_offset_next;
      entry_type       <= entry_type_next;
      entry_length     <= entry_length_next;
      entry_apic_id    <= entry_apic_id_next;
      entry_enabled    <= entry_enabled_next;
      parse_stopped    <= parse_stopped_next;
    end
  end

  // ---------------------------------------------------------------------
  // Id map: registrations write, lookups read
  // ---------------------------------------------------------------------
  always_comb begin
    map_req.clear    = reg_bsp;
    map_req.wr_en    = reg_bsp || reg_entry;
    map_req.wr_id    = reg_bsp ? bsp_apic_id : entry_apic_id;
    map_req.wr_index = reg_bsp ? '0 : madt_lae_pkg::IDX_W'(registered_count);
    map_req.rd_en    = accept && (in_data.operation == madt_lae_pkg::OP_LOOKUP);
    map_req.rd_id    = in_data.query_apic_id;
  end

  madt_lae_map u_map (
    .clk       (clk),
    .rst       (rst),
    .req       (map_req),
    .chk_id    (entry_apic_id),
    .chk_valid (chk_valid),
    .rd_hit    (rd_hit),
    .rd_index  (rd_index)
  );

  // ---------------------------------------------------------------------
  // Result stage: holds one item's pending results (at most two)
  // ---------------------------------------------------------------------
  logic                           s1_valid;
  logic                           s1_lookup;
  logic                           s1_has_reg;
  logic                           s1_has_done;
  logic [madt_lae_pkg::IDX_W-1:0] s1_reg_index;
  logic [madt_lae_pkg::ID_W-1:0]  s1_id;
  logic [CntW-1:0]                s1_count;
  logic                           s1_stopped;

  logic                           out_free;
  logic                           s1_advance;
  logic                           s1_release;
  madt_lae_pkg::result_t          res;

  assign has_results = map_req.rd_en || reg_bsp || reg_entry ||
                       (accept_byte && in_data.last_byte);
  assign out_free    = !out_valid || out_ready;
  assign s1_advance  = s1_valid && out_free;
  assign s1_release  = s1_advance && (s1_lookup || !(s1_has_reg && s1_has_done));
  assign in_ready    = !s1_valid || s1_release;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= has_results;
    end else if (s1_release) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload: capture on accept; drop the registration once it moves out.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lookup    <= map_req.rd_en;
      s1_has_reg   <= reg_bsp || reg_entry;
      s1_has_done  <= accept_byte && in_data.last_byte;
      s1_reg_index <= map_req.wr_index;
      s1_id        <= map_req.rd_en ? in_data.query_apic_id : map_req.wr_id;
      s1_count     <= map_req.rd_en ? registered_count : registered_count_next;
      s1_stopped   <= map_req.rd_en ? parse_stopped : parse_stopped_next;
    end else if (s1_advance && !s1_lookup && s1_has_reg) begin
      s1_has_reg <= 1'b0;
    end
  end

  // Select the next result of the held item.
  always_comb begin
    res.cpu_count = madt_lae_pkg::CNT_OUT_W'(s1_count);
    res.malformed = s1_stopped;
    if (s1_lookup) begin
      res.result_kind = madt_lae_pkg::KIND_LOOKUP;
      res.proc_index  = rd_hit ? rd_index : '0;
      res.apic_id     = s1_id;
      res.found       = rd_hit;
      res.last_result = 1'b1;
    end else if (s1_has_reg) begin
      res.result_kind = madt_lae_pkg::KIND_CPU;
      res.proc_index  = s1_reg_index;
      res.apic_id     = s1_id;
      res.found       = 1'b0;
      res.last_result = !s1_has_done;
    end else begin
      res.result_kind = madt_lae_pkg::KIND_DONE;
      res.proc_index  = '0;
      res.apic_id     = '0;
      res.found       = 1'b0;
      res.last_result = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    registered_count <= MaxCnt)
    else $error("processor count beyond MAX_CPUS");

  a_first_bsp: assert property (@(posedge clk) disable iff (rst)
    (accept_byte && in_data.first_byte) |=> (registered_count == CntW'(1)))
    else $error("first byte did not leave exactly the boot processor");

  a_stop_offset: assert property (@(posedge clk) disable iff (rst)
    parse_stopped |-> (entry_offset == '0))
    else $error("stopped parser holds a nonzero entry offset");

  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.result_kind == madt_lae_pkg::KIND_LOOKUP && !out_data.found)
    |-> (out_data.proc_index == '0))
    else $error("lookup miss reports a nonzero index");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && !s1_lookup && s1_has_reg && s1_has_done)
    |=> (s1_valid && !s1_has_reg && s1_has_done))
    else $error("done result lost after a registration");
`endif

endmodule
